/* src/dfsec_pkg.sv */
// shared types, constants and helpers of the dfs edge classifier
`timescale 1ns / 1ps
package dfsec_pkg;

  localparam int VW = 5;
  localparam int TIME_PORT_W = 6;
  localparam int N_W = 9;
  localparam int EDGE_ADDR_MAX_W = 10;
  localparam int EDGE_CNT_MAX_W = 11;
  localparam int QUEUE_DEPTH = 2;
  localparam int DEF_MAX_VERTICES = 16;
  localparam int DEF_MAX_EDGES = 32;
  localparam logic [VW-1:0] VERTEX_COUNT_RESET = 5'd16;

  localparam logic [1:0] CLS_TREE = 2'd0;
  localparam logic [1:0] CLS_BACK = 2'd1;
  localparam logic [1:0] CLS_FORWARD = 2'd2;
  localparam logic [1:0] CLS_CROSS = 2'd3;

  localparam logic REC_VERTEX = 1'b0;
  localparam logic REC_EDGE = 1'b1;

  typedef enum logic [1:0] {
    WHITE,
    GRAY,
    BLACK
  } colour_t;

  typedef struct packed {
    logic [VW-1:0] src;
    logic [VW-1:0] dst;
  } edge_t;

  typedef struct packed {
    logic en;
    logic [EDGE_ADDR_MAX_W-1:0] addr;
    edge_t data;
  } edge_wr_t;

  typedef struct packed {
    logic [EDGE_CNT_MAX_W-1:0] cnt;
    logic drop;
    logic [VW-1:0] max_v;
  } job_t;

  typedef struct packed {
    logic idle;
    logic done;
  } back_stat_t;

  function automatic logic [N_W-1:0] eff_count(input logic [VW-1:0] vc,
                                                input logic [N_W-1:0] maxv);
    logic [N_W-1:0] v;
    v = N_W'(vc);
    priority if (v == '0) v = N_W'(1);
    else if (v > maxv) v = maxv;
    return v;
  endfunction

endpackage

/* src/dfsec_queue.sv */
// two entry job queue between intake and search engine
`timescale 1ns / 1ps
module dfsec_queue
  import dfsec_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  job_t push_data,
  input  logic push_valid,
  output logic push_ready,
  output job_t pop_data,
  output logic pop_valid,
  input  logic pop_ready
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t mem [0:QUEUE_DEPTH-1];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic push_fire;
  logic pop_fire;

  assign push_ready = (count != CW'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data = mem[rd_ptr];
  assign push_fire = push_valid && push_ready;
  assign pop_fire = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push_fire && !pop_fire) begin
        count <= count + CW'(1);
      end else if (pop_fire && !push_fire) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* src/dfsec_front.sv */
// intake: edge checks, edge store writes and search job issue
`timescale 1ns / 1ps
module dfsec_front
  import dfsec_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_EDGES = DEF_MAX_EDGES
) (
  input  logic clk,
  input  logic rst,
  input  logic [VW-1:0] vertex_count,
  input  logic [VW-1:0] from_vertex,
  input  logic [VW-1:0] to_vertex,
  input  logic has_edge,
  input  logic last_edge,
  input  logic in_valid,
  output logic in_ready,
  output edge_wr_t edge_wr,
  output job_t job,
  output logic job_valid,
  input  logic job_ready,
  input  back_stat_t stat,
  output logic busy
);

  localparam int ECW = $clog2(MAX_EDGES + 1);

  logic [ECW-1:0] edge_total;
  logic [ECW-1:0] edge_total_next;
  logic drop;
  logic drop_next;
  logic [VW-1:0] max_v;
  logic [VW-1:0] max_next;
  logic [N_W-1:0] n;
  logic fire;
  logic ok;
  logic store;

  assign n = eff_count(vertex_count, N_W'(MAX_VERTICES));
  assign in_ready = !busy && job_ready;
  assign fire = in_valid && in_ready;
  assign ok = (from_vertex != '0) && (to_vertex != '0) &&
              (N_W'(from_vertex) <= n) && (N_W'(to_vertex) <= n) &&
              (edge_total < ECW'(MAX_EDGES));
  assign store = fire && has_edge && ok;

  always_comb begin
    edge_total_next = edge_total + ECW'(store);
    drop_next = drop || (fire && has_edge && !ok);
    max_next = max_v;
    if (store) begin
      if (from_vertex > max_next) max_next = from_vertex;
      if (to_vertex > max_next) max_next = to_vertex;
    end
  end

  assign edge_wr.en = store;
  assign edge_wr.addr = EDGE_ADDR_MAX_W'(edge_total);
  assign edge_wr.data.src = from_vertex;
  assign edge_wr.data.dst = to_vertex;

  assign job.cnt = EDGE_CNT_MAX_W'(edge_total_next);
  assign job.drop = drop_next;
  assign job.max_v = max_next;
  assign job_valid = fire && last_edge;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      edge_total <= '0;
      drop <= 1'b0;
      max_v <= '0;
    end else if (stat.done) begin
      busy <= 1'b0;
      edge_total <= '0;
      drop <= 1'b0;
      max_v <= '0;
    end else if (fire) begin
      edge_total <= edge_total_next;
      drop <= drop_next;
      max_v <= max_next;
      if (last_edge) begin
        busy <= 1'b1;
      end
    end
  end

endmodule

/* src/dfsec_back.sv */
// search engine: depth-first walk, edge classes and record output
`timescale 1ns / 1ps
module dfsec_back
  import dfsec_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_EDGES = DEF_MAX_EDGES
) (
  input  logic clk,
  input  logic rst,
  input  logic [VW-1:0] vertex_count,
  input  edge_wr_t edge_wr,
  input  job_t job,
  input  logic job_valid,
  output logic job_ready,
  output back_stat_t stat,
  output logic out_valid,
  input  logic out_ready,
  output logic record_kind,
  output logic [VW-1:0] vertex_a,
  output logic [VW-1:0] vertex_b,
  output logic [VW-1:0] parent_vertex,
  output logic [TIME_PORT_W-1:0] discover_time,
  output logic [TIME_PORT_W-1:0] finish_time,
  output logic [1:0] edge_class,
  output logic edges_dropped,
  output logic last_record
);

  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int SAW = $clog2(MAX_VERTICES);
  localparam int SCW = $clog2(MAX_VERTICES + 1);
  localparam int TW = $clog2(2 * MAX_VERTICES + 1);
  localparam int VDEPTH = 1 << VW;

  typedef enum logic [3:0] {
    S_IDLE, S_ROOT, S_FETCH, S_CHECK, S_CLASS, S_FINISH, S_POP,
    S_VADDR, S_VLOOK, S_VOUT, S_EADDR, S_EOUT, S_DONE
  } state_t;

  typedef struct packed {
    logic [VW-1:0] u;
    logic [ECW-1:0] j;
    logic [TW-1:0] d;
  } frame_t;

  typedef struct packed {
    logic [VW-1:0] src;
    logic [VW-1:0] dst;
    logic [1:0] cls;
  } class_rec_t;

  state_t state;
  edge_t edge_mem [0:MAX_EDGES-1];
  logic [TW-1:0] disc_mem [0:VDEPTH-1];
  logic [TW-1:0] fin_mem [0:VDEPTH-1];
  logic [VW-1:0] par_mem [0:VDEPTH-1];
  frame_t stack_mem [0:MAX_VERTICES-1];
  logic [VW-1:0] visit_mem [0:MAX_VERTICES-1];
  class_rec_t class_mem [0:MAX_EDGES-1];
  colour_t color [0:VDEPTH-1];

  edge_t edge_rd;
  logic [TW-1:0] disc_rd;
  logic [TW-1:0] fin_rd;
  logic [VW-1:0] par_rd;
  frame_t stack_rd;
  logic [VW-1:0] visit_rd;
  class_rec_t class_rd;

  logic [N_W-1:0] n;
  logic [ECW-1:0] et;
  logic drop;
  logic [N_W-1:0] r;
  logic [TW-1:0] clk_cnt;
  logic [SCW-1:0] nv;
  logic [ECW-1:0] nc;
  logic [SCW-1:0] sp;
  frame_t cur;
  logic [VW-1:0] cand_v;
  logic [VW-1:0] rec_v;
  logic [SCW-1:0] vi;
  logic [ECW-1:0] ei;

  logic [N_W-1:0] n_now;
  logic [VW-1:0] disc_raddr;
  logic disc_go;
  logic [VW-1:0] disc_v;
  logic [VW-1:0] disc_par;
  logic [1:0] cls;
  logic out_free;
  logic [TW-1:0] clk_inc;

  assign n_now = eff_count(vertex_count, N_W'(MAX_VERTICES));
  assign job_ready = (state == S_IDLE);
  assign stat.idle = (state == S_IDLE);
  assign stat.done = (state == S_DONE);
  assign out_free = !out_valid || out_ready;
  assign clk_inc = clk_cnt + TW'(1);
  assign disc_raddr = (state == S_VLOOK || state == S_VOUT) ? visit_rd : edge_rd.dst;

  always_comb begin
    disc_go = 1'b0;
    disc_v = cand_v;
    disc_par = cur.u;
    if (state == S_ROOT && r <= n && color[r[VW-1:0]] == WHITE) begin
      disc_go = 1'b1;
      disc_v = r[VW-1:0];
      disc_par = '0;
    end else if (state == S_CLASS && color[cand_v] == WHITE &&
                 sp < SCW'(MAX_VERTICES)) begin
      disc_go = 1'b1;
    end
  end

  always_comb begin
    unique case (color[cand_v])
      WHITE: cls = CLS_TREE;
      GRAY: cls = CLS_BACK;
      default: cls = (cur.d < disc_rd) ? CLS_FORWARD : CLS_CROSS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (edge_wr.en) begin
      edge_mem[edge_wr.addr[EAW-1:0]] <= edge_wr.data;
    end
    edge_rd <= edge_mem[cur.j[EAW-1:0]];
    disc_rd <= disc_mem[disc_raddr];
    fin_rd <= fin_mem[visit_rd];
    par_rd <= par_mem[visit_rd];
    stack_rd <= stack_mem[SAW'(sp - SCW'(2))];
    visit_rd <= visit_mem[vi[SAW-1:0]];
    class_rd <= class_mem[ei[EAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      for (int k = 0; k < VDEPTH; k++) color[k] <= WHITE;
    end else begin
      if (out_valid && out_ready && state != S_VOUT && state != S_EOUT) out_valid <= 1'b0;
      if (disc_go) begin
        color[disc_v] <= GRAY;
        clk_cnt <= clk_inc;
        disc_mem[disc_v] <= clk_inc;
        par_mem[disc_v] <= disc_par;
        visit_mem[nv[SAW-1:0]] <= disc_v;
        nv <= nv + SCW'(1);
        if (sp != '0) stack_mem[SAW'(sp - SCW'(1))] <= cur;
        cur.u <= disc_v;
        cur.j <= '0;
        cur.d <= clk_inc;
        sp <= sp + SCW'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            n <= n_now;
            et <= ECW'(job.cnt);
            drop <= job.drop || (N_W'(job.max_v) > n_now);
            r <= N_W'(1);
            clk_cnt <= '0;
            nv <= '0;
            nc <= '0;
            sp <= '0;
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (r > n) begin
            vi <= '0;
            state <= S_VADDR;
          end else if (disc_go) begin
            state <= S_FETCH;
          end else begin
            r <= r + N_W'(1);
          end
        end
        S_FETCH: begin
          state <= (cur.j >= et) ? S_FINISH : S_CHECK;
        end
        S_CHECK: begin
          cur.j <= cur.j + ECW'(1);
          if (edge_rd.src == cur.u && edge_rd.dst != '0 &&
              N_W'(edge_rd.dst) <= n) begin
            cand_v <= edge_rd.dst;
            state <= S_CLASS;
          end else begin
            state <= S_FETCH;
          end
        end
        S_CLASS: begin
          class_mem[nc[EAW-1:0]] <= '{src: cur.u, dst: cand_v, cls: cls};
          nc <= nc + ECW'(1);
          state <= S_FETCH;
        end
        S_FINISH: begin
          color[cur.u] <= BLACK;
          clk_cnt <= clk_inc;
          fin_mem[cur.u] <= clk_inc;
          sp <= sp - SCW'(1);
          state <= (sp == SCW'(1)) ? S_ROOT : S_POP;
        end
        S_POP: begin
          cur <= stack_rd;
          state <= S_FETCH;
        end
        S_VADDR: begin
          state <= S_VLOOK;
        end
        S_VLOOK: begin
          rec_v <= visit_rd;
          state <= S_VOUT;
        end
        S_VOUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            record_kind <= REC_VERTEX;
            vertex_a <= rec_v;
            vertex_b <= '0;
            parent_vertex <= par_rd;
            discover_time <= TIME_PORT_W'(disc_rd);
            finish_time <= TIME_PORT_W'(fin_rd);
            edge_class <= CLS_TREE;
            edges_dropped <= drop;
            last_record <= (vi + SCW'(1) == nv) && (nc == '0);
            vi <= vi + SCW'(1);
            if (vi + SCW'(1) != nv) begin
              state <= S_VADDR;
            end else if (nc == '0) begin
              state <= S_DONE;
            end else begin
              ei <= '0;
              state <= S_EADDR;
            end
          end
        end
        S_EADDR: begin
          state <= S_EOUT;
        end
        S_EOUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            record_kind <= REC_EDGE;
            vertex_a <= class_rd.src;
            vertex_b <= class_rd.dst;
            parent_vertex <= '0;
            discover_time <= '0;
            finish_time <= '0;
            edge_class <= class_rd.cls;
            edges_dropped <= drop;
            last_record <= (ei + ECW'(1) == nc);
            ei <= ei + ECW'(1);
            state <= (ei + ECW'(1) == nc) ? S_DONE : S_EADDR;
          end
        end
        S_DONE: begin
          for (int k = 0; k < VDEPTH; k++) color[k] <= WHITE;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/dfs_edge_classifier_unit.sv */
// top level of the dfs edge classifier
`timescale 1ns / 1ps
// Loads directed edges one item per cycle, while in_ready is high, into an
// edge store. The item with last_edge set is accepted and intake then stays
// closed while the search engine walks the graph: each adjacency scan reads
// the edge store through one port, one stored edge per pass through the
// FETCH and CHECK states. Vertex records then leave through the VADDR,
// VLOOK and VOUT states and edge records through EADDR and EOUT, each held
// while out_ready is low. Intake reopens once the engine reaches S_DONE.
// vertex_count is read when an edge is checked and again when the search starts.
module dfs_edge_classifier_unit
  import dfsec_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_EDGES = DEF_MAX_EDGES
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [VW-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [VW-1:0] from_vertex,
  input  logic [VW-1:0] to_vertex,
  input  logic has_edge,
  input  logic last_edge,
  output logic out_valid,
  input  logic out_ready,
  output logic record_kind,
  output logic [VW-1:0] vertex_a,
  output logic [VW-1:0] vertex_b,
  output logic [VW-1:0] parent_vertex,
  output logic [TIME_PORT_W-1:0] discover_time,
  output logic [TIME_PORT_W-1:0] finish_time,
  output logic [1:0] edge_class,
  output logic edges_dropped,
  output logic last_record
);

  logic [VW-1:0] vertex_count;
  edge_wr_t edge_wr;
  job_t push_job;
  logic push_valid;
  logic push_ready;
  job_t pop_job;
  logic pop_valid;
  logic pop_ready;
  back_stat_t stat;
  logic front_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      vertex_count <= cfg_data;
    end
  end

  dfsec_front #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_EDGES(MAX_EDGES)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .vertex_count(vertex_count),
    .from_vertex(from_vertex),
    .to_vertex(to_vertex),
    .has_edge(has_edge),
    .last_edge(last_edge),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .edge_wr(edge_wr),
    .job(push_job),
    .job_valid(push_valid),
    .job_ready(push_ready),
    .stat(stat),
    .busy(front_busy)
  );

  dfsec_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push_data(push_job),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .pop_data(pop_job),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready)
  );

  dfsec_back #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_EDGES(MAX_EDGES)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .vertex_count(vertex_count),
    .edge_wr(edge_wr),
    .job(pop_job),
    .job_valid(pop_valid),
    .job_ready(pop_ready),
    .stat(stat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .record_kind(record_kind),
    .vertex_a(vertex_a),
    .vertex_b(vertex_b),
    .parent_vertex(parent_vertex),
    .discover_time(discover_time),
    .finish_time(finish_time),
    .edge_class(edge_class),
    .edges_dropped(edges_dropped),
    .last_record(last_record)
  );

  a_job_while_busy: assert property (@(posedge clk) disable iff (rst)
    (pop_valid && pop_ready) |-> front_busy)
    else $error("search job taken while intake open");

  a_store_write_idle: assert property (@(posedge clk) disable iff (rst)
    edge_wr.en |-> stat.idle)
    else $error("edge store written during search");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> (front_busy && !in_ready))
    else $error("search finished with intake open");

endmodule

/* sim/dfs_edge_classifier_unit_tb.sv */
// testbench of the dfs edge classifier: random edge lists checked against a search predictor
`timescale 1ns / 1ps
module dfs_edge_classifier_unit_tb;
  import dfsec_pkg::*;

  typedef struct packed {
    logic [VW-1:0] from_v;
    logic [VW-1:0] to_v;
    logic has;
    logic last;
  } edge_item_t;

  typedef struct packed {
    logic kind;
    logic [VW-1:0] a;
    logic [VW-1:0] b;
    logic [VW-1:0] par;
    logic [TIME_PORT_W-1:0] d;
    logic [TIME_PORT_W-1:0] f;
    logic [1:0] cls;
    logic drop;
    logic lastr;
  } dfs_record_t;

  localparam int WATCH_LIMIT = 40000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [VW-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [VW-1:0] from_vertex = '0;
  logic [VW-1:0] to_vertex = '0;
  logic has_edge = 0;
  logic last_edge = 0;
  logic out_valid;
  logic out_ready = 0;
  logic record_kind;
  logic [VW-1:0] vertex_a, vertex_b, parent_vertex;
  logic [TIME_PORT_W-1:0] discover_time, finish_time;
  logic [1:0] edge_class;
  logic edges_dropped, last_record;

  dfs_edge_classifier_unit uut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  edge_item_t pending_edges_q[$];
  dfs_record_t dfs_records_q[$];
  int errors = 0;
  int items_sent = 0;
  bit calm = 0;

  // predictor state
  logic [VW-1:0] vcount = VERTEX_COUNT_RESET;
  int e_src[DEF_MAX_EDGES];
  int e_dst[DEF_MAX_EDGES];
  int e_total = 0;
  bit e_drop = 0;

  function automatic int count_eff(input logic [VW-1:0] vc);
    if (vc == 0) return 1;
    if (vc > DEF_MAX_VERTICES) return DEF_MAX_VERTICES;
    return vc;
  endfunction

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic void classify_graph();
    colour_t col[DEF_MAX_VERTICES+1];
    int disc[DEF_MAX_VERTICES+1];
    int fin[DEF_MAX_VERTICES+1];
    int par[DEF_MAX_VERTICES+1];
    int stk_v[DEF_MAX_VERTICES];
    int stk_j[DEF_MAX_VERTICES];
    int visit[DEF_MAX_VERTICES];
    int c_edge[DEF_MAX_EDGES];
    logic [1:0] c_kind[DEF_MAX_EDGES];
    int n, sp, nv, nc, tick, u, j, v;
    dfs_record_t rec;
    n = count_eff(vcount);
    sp = 0; nv = 0; nc = 0; tick = 0;
    for (int i = 0; i <= DEF_MAX_VERTICES; i++) col[i] = WHITE;
    for (int i = 0; i < e_total; i++)
      if (e_src[i] > n || e_dst[i] > n) e_drop = 1;
    for (int r = 1; r <= n; r++) begin
      if (col[r] != WHITE) continue;
      col[r] = GRAY; disc[r] = ++tick; par[r] = 0; visit[nv++] = r;
      stk_v[sp] = r; stk_j[sp] = 0; sp++;
      while (sp > 0) begin
        u = stk_v[sp-1];
        j = stk_j[sp-1];
        while (j < e_total && !(e_src[j] == u && e_dst[j] >= 1 && e_dst[j] <= n)) j++;
        if (j < e_total) begin
          v = e_dst[j];
          stk_j[sp-1] = j + 1;
          c_edge[nc] = j;
          if (col[v] == WHITE) c_kind[nc] = CLS_TREE;
          else if (col[v] == GRAY) c_kind[nc] = CLS_BACK;
          else if (disc[u] < disc[v]) c_kind[nc] = CLS_FORWARD;
          else c_kind[nc] = CLS_CROSS;
          nc++;
          if (col[v] == WHITE && sp < DEF_MAX_VERTICES) begin
            col[v] = GRAY; disc[v] = ++tick; par[v] = u; visit[nv++] = v;
            stk_v[sp] = v; stk_j[sp] = 0; sp++;
          end
        end else begin
          sp--;
          col[u] = BLACK;
          fin[u] = ++tick;
        end
      end
    end
    for (int i = 0; i < nv + nc; i++) begin
      rec = '0;
      rec.drop = e_drop;
      rec.lastr = (i == nv + nc - 1);
      if (i < nv) begin
        rec.kind = REC_VERTEX;
        rec.a = VW'(visit[i]);
        rec.par = VW'(par[visit[i]]);
        rec.d = TIME_PORT_W'(disc[visit[i]]);
        rec.f = TIME_PORT_W'(fin[visit[i]]);
      end else begin
        rec.kind = REC_EDGE;
        rec.a = VW'(e_src[c_edge[i-nv]]);
        rec.b = VW'(e_dst[c_edge[i-nv]]);
        rec.cls = c_kind[i-nv];
      end
      dfs_records_q.insert(dfs_records_q.size(), rec);
    end
    e_total = 0;
    e_drop = 0;
  endfunction

  function automatic void take_edge(input edge_item_t it);
    int n;
    n = count_eff(vcount);
    if (it.has) begin
      if (it.from_v == 0 || it.from_v > n || it.to_v == 0 || it.to_v > n ||
          e_total >= DEF_MAX_EDGES) begin
        e_drop = 1;
      end else begin
        e_src[e_total] = it.from_v;
        e_dst[e_total] = it.to_v;
        e_total++;
      end
    end
    if (it.last) classify_graph();
  endfunction

  // input driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        take_edge('{from_vertex, to_vertex, has_edge, last_edge});
      if (in_valid && !in_ready) begin
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 0;
      end else if (pending_edges_q.size() > 0) begin
        if (!calm && $urandom_range(0, 5) == 0) begin
          in_gap <= $urandom_range(1, 9) - 1;
          in_valid <= 0;
        end else begin
          {from_vertex, to_vertex, has_edge, last_edge} <= pending_edges_q.pop_front();
          in_valid <= 1;
        end
      end else begin
        in_valid <= 0;
      end
    end
  end

  // result monitor
  int out_gap = 0;
  always @(posedge clk) begin
    dfs_record_t w;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (dfs_records_q.size() == 0) begin
          report("unexpected record kind", record_kind, 0);
        end else begin
          w = dfs_records_q.pop_front();
          if (record_kind !== w.kind) report("record_kind", record_kind, w.kind);
          if (vertex_a !== w.a) report("vertex_a", vertex_a, w.a);
          if (vertex_b !== w.b) report("vertex_b", vertex_b, w.b);
          if (parent_vertex !== w.par) report("parent_vertex", parent_vertex, w.par);
          if (discover_time !== w.d) report("discover_time", discover_time, w.d);
          if (finish_time !== w.f) report("finish_time", finish_time, w.f);
          if (edge_class !== w.cls) report("edge_class", edge_class, w.cls);
          if (edges_dropped !== w.drop) report("edges_dropped", edges_dropped, w.drop);
          if (last_record !== w.lastr) report("last_record", last_record, w.lastr);
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_gap <= $urandom_range(1, 9) - 1;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  always @(posedge clk)
    if (!rst && cfg_valid && cfg_ready) vcount <= cfg_data;

  // watchdog
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_edge(input int f, input int t, input bit h, input bit l);
    edge_item_t it;
    it = '{f[VW-1:0], t[VW-1:0], h, l};
    pending_edges_q.insert(pending_edges_q.size(), it);
    items_sent++;
  endtask

  task automatic settle();
    while (pending_edges_q.size() > 0 || in_valid || dfs_records_q.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_count(input int v);
    settle();
    cfg_valid <= 1;
    cfg_data <= v[VW-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic random_graph(input int ne);
    int n;
    n = count_eff(vcount);
    for (int i = 0; i < ne; i++) begin
      if ($urandom_range(0, 15) == 0)
        push_edge($urandom_range(0, 31), $urandom_range(0, 31), 0, 0);
      if ($urandom_range(0, 11) == 0)
        push_edge($urandom_range(0, 1) ? 0 : $urandom_range(0, 31),
                  $urandom_range(0, 31), 1, 0);
      else
        push_edge($urandom_range(1, n), $urandom_range(1, n), 1, 0);
    end
    if ($urandom_range(0, 1))
      push_edge($urandom_range(0, 31), $urandom_range(0, 31), 0, 1);
    else
      push_edge($urandom_range(1, n), $urandom_range(1, n), 1, 1);
  endtask

  initial begin
    int vc;
    repeat (5) @(posedge clk);
    rst <= 0;
    // mixed classes, self loop, duplicate, bad endpoints
    push_edge(1, 2, 1, 0); push_edge(2, 3, 1, 0); push_edge(3, 1, 1, 0);
    push_edge(1, 3, 1, 0); push_edge(4, 4, 1, 0); push_edge(4, 2, 1, 0);
    push_edge(1, 2, 1, 0); push_edge(0, 5, 1, 0); push_edge(17, 1, 1, 0);
    push_edge(16, 31, 1, 0); push_edge(16, 16, 1, 0); push_edge(0, 0, 0, 1);
    // empty graph
    push_edge(31, 31, 0, 1);
    write_count(1);
    push_edge(1, 1, 1, 0); push_edge(1, 2, 1, 1);
    write_count(0);
    push_edge(1, 1, 1, 1);
    // count shrunk after loading
    write_count(16);
    push_edge(5, 6, 1, 0); push_edge(1, 5, 1, 0); push_edge(1, 2, 1, 0);
    write_count(4);
    push_edge(0, 0, 0, 1);
    // store overflow
    write_count(31);
    for (int i = 0; i < 34; i++)
      push_edge($urandom_range(1, 16), $urandom_range(1, 16), 1, i == 33);
    while (items_sent < 190) begin
      case ($urandom_range(0, 7))
        0: vc = 0;
        1: vc = $urandom_range(17, 31);
        2: vc = 16;
        default: vc = $urandom_range(1, 16);
      endcase
      if ($urandom_range(0, 2) != 0) write_count(vc);
      if (items_sent > 160) calm = 1;
      random_graph($urandom_range(0, 14));
    end
    settle();
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
src/dfsec_pkg.sv
src/dfsec_queue.sv
src/dfsec_front.sv
src/dfsec_back.sv
src/dfs_edge_classifier_unit.sv
sim/dfs_edge_classifier_unit_tb.sv
